// ===== rtl/i2cbe_pkg.sv =====
// Shared types, command and pin-action codes, and phase lookup functions
// for the I2C master bit engine. No dependencies.
package i2cbe_pkg;

  localparam int unsigned TicksW = 16;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned ByteW  = 8;

  localparam logic [TicksW-1:0] PhaseTicksRst = 16'd10;
  localparam logic [TicksW-1:0] TickMax       = 16'hFFFF;
  localparam logic [ByteW-1:0]  MsbMask       = 8'h80;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_SEND_ACK = 3'd4,
    CMD_GET_ACK  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_SDA0   = 3'd0,
    ACT_SDA1   = 3'd1,
    ACT_SDABIT = 3'd2,
    ACT_SCL0   = 3'd3,
    ACT_SCL1   = 3'd4,
    ACT_RDBIT  = 3'd5,
    ACT_RDACK  = 3'd6
  } act_e;

  typedef struct packed {
    logic             req;
    logic [2:0]       cmd;
    logic [ByteW-1:0] tx_byte;
    logic             ack_value;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic             cmd_dropped;
    logic             ack_seen;
    logic [ByteW-1:0] rx_byte;
    logic             done;
    logic             busy;
    logic             sda_drive;
    logic             scl_drive;
  } res_t;

  function automatic logic cmd_known(logic [2:0] cmd);
    return (cmd <= CMD_GET_ACK);
  endfunction

  function automatic logic [PhaseW-1:0] seq_len(logic [2:0] cmd);
    logic [PhaseW-1:0] len;
    len = 5'd4;
    unique case (cmd)
      CMD_START:    len = 5'd4;
      CMD_STOP:     len = 5'd3;
      CMD_WRITE:    len = 5'd24;
      CMD_READ:     len = 5'd25;
      CMD_SEND_ACK: len = 5'd3;
      default:      len = 5'd4;
    endcase
    return len;
  endfunction

  // step is the position inside a three-phase bit slot
  function automatic act_e phase_action(logic [2:0] cmd, logic [PhaseW-1:0] ph,
                                        logic [1:0] step);
    act_e act;
    act = ACT_SDA1;
    unique case (cmd)
      CMD_START: begin
        case (ph[1:0])
          2'd0:    act = ACT_SDA1;
          2'd1:    act = ACT_SCL1;
          2'd2:    act = ACT_SDA0;
          default: act = ACT_SCL0;
        endcase
      end
      CMD_STOP: begin
        case (ph[1:0])
          2'd0:    act = ACT_SDA0;
          2'd1:    act = ACT_SCL1;
          default: act = ACT_SDA1;
        endcase
      end
      CMD_WRITE, CMD_SEND_ACK: begin
        case (step)
          2'd0:    act = ACT_SDABIT;
          2'd1:    act = ACT_SCL1;
          default: act = ACT_SCL0;
        endcase
      end
      CMD_READ: begin
        if (ph == '0) begin
          act = ACT_SDA1;
        end else begin
          case (step)
            2'd0:    act = ACT_SCL1;
            2'd1:    act = ACT_RDBIT;
            default: act = ACT_SCL0;
          endcase
        end
      end
      default: begin
        case (ph[1:0])
          2'd0:    act = ACT_SDA1;
          2'd1:    act = ACT_SCL1;
          2'd2:    act = ACT_RDACK;
          default: act = ACT_SCL0;
        endcase
      end
    endcase
    return act;
  endfunction

endpackage

// ===== rtl/i2cbe_in_reg.sv =====
// Input register stage of the I2C master bit engine: holds one item
// until the core takes it. Depends on i2cbe_pkg.
module i2cbe_in_reg import i2cbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || pop_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== rtl/i2cbe_core.sv =====
// Command state, phase timer and pin actions of the I2C master bit engine;
// one item updates the state per cycle while adv_i is high. Depends on i2cbe_pkg.
module i2cbe_core import i2cbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TicksW-1:0] cfg_wdata_i,
  input  logic              adv_i,
  input  item_t             item_i,
  output res_t              res_o
);

  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [2:0]        cmd_q, cmd_d;
  logic              busy_q, busy_d;
  logic [PhaseW-1:0] ph_q, ph_d;
  logic [1:0]        step_q, step_d;
  logic [TicksW-1:0] tick_q, tick_d;
  logic [ByteW-1:0]  so_q, so_d;
  logic [ByteW-1:0]  si_q, si_d;
  logic              ack_q, ack_d;
  logic [TicksW-1:0] pt_q;

  logic              done;
  logic              dropped;
  logic              act_en;
  logic [2:0]        act_cmd;
  logic [PhaseW-1:0] act_ph;
  logic [1:0]        act_step;
  logic [ByteW-1:0]  so_src;
  logic [TicksW-1:0] limit;
  logic [TicksW-1:0] tick_inc;
  logic [PhaseW-1:0] ph_nx;
  logic [1:0]        step_nx;
  act_e              act;

  always_comb begin
    scl_d    = scl_q;
    sda_d    = sda_q;
    cmd_d    = cmd_q;
    busy_d   = busy_q;
    ph_d     = ph_q;
    step_d   = step_q;
    tick_d   = tick_q;
    si_d     = si_q;
    ack_d    = ack_q;
    so_src   = so_q;
    done     = 1'b0;
    dropped  = 1'b0;
    act_en   = 1'b0;
    act_cmd  = cmd_q;
    act_ph   = ph_q;
    act_step = step_q;
    limit    = (pt_q == '0) ? TicksW'(1) : pt_q;
    tick_inc = (tick_q != TickMax) ? tick_q + TicksW'(1) : tick_q;
    ph_nx    = ph_q + PhaseW'(1);
    if ((cmd_q == CMD_READ) && (ph_q == '0)) begin
      step_nx = 2'd0;
    end else begin
      step_nx = (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
    end

    if (adv_i) begin
      if (item_i.req) begin
        if (busy_q) begin
          dropped = 1'b1;
        end else if (cmd_known(item_i.cmd)) begin
          cmd_d    = item_i.cmd;
          busy_d   = 1'b1;
          ph_d     = '0;
          step_d   = '0;
          tick_d   = '0;
          act_en   = 1'b1;
          act_cmd  = item_i.cmd;
          act_ph   = '0;
          act_step = '0;
          if (item_i.cmd == CMD_WRITE) begin
            so_src = item_i.tx_byte;
          end else if (item_i.cmd == CMD_SEND_ACK) begin
            so_src = item_i.ack_value ? MsbMask : '0;
          end
        end
      end else if (busy_q) begin
        if (tick_inc >= limit) begin
          tick_d = '0;
          if (ph_nx >= seq_len(cmd_q)) begin
            busy_d = 1'b0;
            ph_d   = '0;
            done   = 1'b1;
          end else begin
            ph_d     = ph_nx;
            step_d   = step_nx;
            act_en   = 1'b1;
            act_ph   = ph_nx;
            act_step = step_nx;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
    end

    act  = phase_action(act_cmd, act_ph, act_step);
    so_d = so_src;
    if (act_en) begin
      case (act)
        ACT_SDA0: sda_d = 1'b0;
        ACT_SDA1: sda_d = 1'b1;
        ACT_SDABIT: begin
          sda_d = so_src[ByteW-1];
          so_d  = {so_src[ByteW-2:0], 1'b0};
        end
        ACT_SCL0:  scl_d = 1'b0;
        ACT_SCL1:  scl_d = 1'b1;
        ACT_RDBIT: si_d  = {si_q[ByteW-2:0], item_i.sda_in};
        default:   ack_d = item_i.sda_in;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      cmd_q  <= '0;
      busy_q <= 1'b0;
      ph_q   <= '0;
      step_q <= '0;
      tick_q <= '0;
      so_q   <= '0;
      si_q   <= '0;
      ack_q  <= 1'b1;
    end else begin
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      cmd_q  <= cmd_d;
      busy_q <= busy_d;
      ph_q   <= ph_d;
      step_q <= step_d;
      tick_q <= tick_d;
      so_q   <= so_d;
      si_q   <= si_d;
      ack_q  <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= PhaseTicksRst;
    end else if (cfg_we_i) begin
      pt_q <= cfg_wdata_i;
    end
  end

  assign res_o.scl_drive   = scl_d;
  assign res_o.sda_drive   = sda_d;
  assign res_o.busy        = busy_d;
  assign res_o.done        = done;
  assign res_o.rx_byte     = si_d;
  assign res_o.ack_seen    = ack_d;
  assign res_o.cmd_dropped = dropped;

`ifndef SYNTHESIS
  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ph_q < seq_len(cmd_q)))
    else $error("phase index beyond command length");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ((ph_q == '0) && (tick_q == '0)))
    else $error("phase or tick counter not cleared while idle");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 2'd3)
    else $error("bit slot step out of range");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (busy_q && !busy_d))
    else $error("done without ending a running command");
`endif

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// Path: the input register, then the output register around the state
// update in the core; one item per cycle sustained while the output register
// is empty or m_axis_tready takes its result.
// Reset: async active low; lines released, idle, phase_ticks = 10.
// Depends on i2cbe_pkg, i2cbe_in_reg and i2cbe_core.
module i2c_master_bit_engine_unit import i2cbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] command, [10:3] tx_byte, [11] ack_value, [12] sda_in, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [13] cmd_dropped, [15:14] zero
  output logic [15:0] m_axis_tdata
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  adv;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q;

  assign in_item.req       = s_axis_tuser;
  assign in_item.cmd       = s_axis_tdata[2:0];
  assign in_item.tx_byte   = s_axis_tdata[10:3];
  assign in_item.ack_value = s_axis_tdata[11];
  assign in_item.sda_in    = s_axis_tdata[12];

  assign adv = item_valid && (!out_valid_q || m_axis_tready);

  i2cbe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .pop_i      (adv),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  i2cbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (item),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

endmodule

// ===== tb/sv/tb_i2c_master_bit_engine_unit.sv =====
// Self-checking testbench for i2c_master_bit_engine_unit: a line-state predictor
// checks every output transfer against the stream of ticks and commands.
// Depends on i2cbe_pkg and the engine RTL.
module tb_i2c_master_bit_engine_unit;
  import i2cbe_pkg::*;

  localparam logic [2:0] CmdUnused6 = 3'd6;
  localparam logic [2:0] CmdUnused7 = 3'd7;
  localparam logic       ReqTick    = 1'b0;
  localparam logic       ReqCmd     = 1'b1;
  localparam int         SdaLow     = 0;
  localparam int         SdaHigh    = 1;
  localparam int         SdaRand    = 2;
  localparam int         CycleLimit = 500000;

  class i2c_line_scoreboard;
    logic [15:0] phase_ticks;
    logic        scl_q;
    logic        sda_q;
    logic [2:0]  cur_cmd;
    logic        busy;
    logic [4:0]  phase;
    logic [15:0] tick_cnt;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic        ack_q;
    res_t        line_states_q[$];
    int          errors;

    function new();
      phase_ticks = PhaseTicksRst;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      cur_cmd     = CMD_START;
      busy        = 1'b0;
      phase       = '0;
      tick_cnt    = '0;
      tx_shift    = '0;
      rx_shift    = '0;
      ack_q       = 1'b1;
      errors      = 0;
    endfunction

    function int unsigned phase_count(logic [2:0] cmd);
      case (cmd)
        CMD_START:    return 4;
        CMD_STOP:     return 3;
        CMD_WRITE:    return 24;
        CMD_READ:     return 25;
        CMD_SEND_ACK: return 3;
        default:      return 4;
      endcase
    endfunction

    function act_e pin_op(logic [2:0] cmd, int unsigned ph);
      act_e op;
      op = ACT_SDA1;
      case (cmd)
        CMD_START: begin
          case (ph)
            0:       op = ACT_SDA1;
            1:       op = ACT_SCL1;
            2:       op = ACT_SDA0;
            default: op = ACT_SCL0;
          endcase
        end
        CMD_STOP: begin
          case (ph)
            0:       op = ACT_SDA0;
            1:       op = ACT_SCL1;
            default: op = ACT_SDA1;
          endcase
        end
        CMD_WRITE, CMD_SEND_ACK: begin
          case (ph % 3)
            0:       op = ACT_SDABIT;
            1:       op = ACT_SCL1;
            default: op = ACT_SCL0;
          endcase
        end
        CMD_READ: begin
          if (ph == 0) begin
            op = ACT_SDA1;
          end else begin
            case ((ph - 1) % 3)
              0:       op = ACT_SCL1;
              1:       op = ACT_RDBIT;
              default: op = ACT_SCL0;
            endcase
          end
        end
        default: begin
          case (ph)
            0:       op = ACT_SDA1;
            1:       op = ACT_SCL1;
            2:       op = ACT_RDACK;
            default: op = ACT_SCL0;
          endcase
        end
      endcase
      return op;
    endfunction

    function void do_op(act_e op, logic sda);
      case (op)
        ACT_SDA0:   sda_q = 1'b0;
        ACT_SDA1:   sda_q = 1'b1;
        ACT_SDABIT: begin
          sda_q    = tx_shift[7];
          tx_shift = {tx_shift[6:0], 1'b0};
        end
        ACT_SCL0:   scl_q = 1'b0;
        ACT_SCL1:   scl_q = 1'b1;
        ACT_RDBIT:  rx_shift = {rx_shift[6:0], sda};
        default:    ack_q = sda;
      endcase
    endfunction

    function void note_transfer(logic req, logic [2:0] cmd, logic [7:0] tx, logic ackv,
                                logic sda);
      res_t        r;
      logic [15:0] lim;
      r   = '0;
      lim = (phase_ticks == '0) ? 16'd1 : phase_ticks;
      if (req) begin
        if (busy) begin
          r.cmd_dropped = 1'b1;
        end else if (cmd <= CMD_GET_ACK) begin
          cur_cmd  = cmd;
          busy     = 1'b1;
          phase    = '0;
          tick_cnt = '0;
          if (cmd == CMD_WRITE) tx_shift = tx;
          else if (cmd == CMD_SEND_ACK) tx_shift = ackv ? MsbMask : 8'h00;
          do_op(pin_op(cmd, 0), sda);
        end
      end else if (busy) begin
        if (tick_cnt != TickMax) tick_cnt++;
        if (tick_cnt >= lim) begin
          tick_cnt = '0;
          phase++;
          if (phase >= phase_count(cur_cmd)) begin
            busy   = 1'b0;
            phase  = '0;
            r.done = 1'b1;
          end else begin
            do_op(pin_op(cur_cmd, phase), sda);
          end
        end
      end
      r.scl_drive = scl_q;
      r.sda_drive = sda_q;
      r.busy      = busy;
      r.rx_byte   = rx_shift;
      r.ack_seen  = ack_q;
      line_states_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_transfer(logic [15:0] data);
      res_t got;
      res_t want;
      got = res_t'(data[13:0]);
      if (line_states_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transfer %04h", data);
        return;
      end
      want = line_states_q.pop_front();
      cmp("scl_drive", want.scl_drive, got.scl_drive);
      cmp("sda_drive", want.sda_drive, got.sda_drive);
      cmp("busy", want.busy, got.busy);
      cmp("done", want.done, got.done);
      cmp("rx_byte", want.rx_byte, got.rx_byte);
      cmp("ack_seen", want.ack_seen, got.ack_seen);
      cmp("cmd_dropped", want.cmd_dropped, got.cmd_dropped);
    endfunction

    function int pending();
      return line_states_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  i2c_line_scoreboard sb = new();
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  i2c_master_bit_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send(logic req, logic [2:0] cmd, logic [7:0] tx, logic ackv, logic sda);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) src_quiet = ~src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, sda, ackv, tx, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_transfer(req, cmd, tx, ackv, sda);
  endtask

  function automatic logic pick_sda(int mode);
    if (mode == SdaRand) return logic'($urandom_range(0, 1));
    return (mode == SdaHigh);
  endfunction

  task automatic send_tick(int mode);
    send(ReqTick, 3'($urandom_range(0, 7)), 8'($urandom), logic'($urandom_range(0, 1)),
         pick_sda(mode));
  endtask

  task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx, logic ackv, int mode);
    send(ReqCmd, cmd, tx, ackv, pick_sda(mode));
    while (sb.busy) send_tick(mode);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_ticks(logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.phase_ticks = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int n);
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      if (!sb.busy && $urandom_range(0, 99) < 85) begin
        cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
        send(ReqCmd, cmd, 8'($urandom), logic'($urandom_range(0, 1)),
             logic'($urandom_range(0, 1)));
      end else if (sb.busy && $urandom_range(0, 99) < 5) begin
        send(ReqCmd, 3'($urandom_range(0, 7)), 8'($urandom), logic'($urandom_range(0, 1)),
             logic'($urandom_range(0, 1)));
      end else begin
        send_tick(SdaRand);
      end
    end
  endtask

  initial begin
    int unsigned gap;
    int          taken;
    m_axis_tready <= 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) snk_quiet = ~snk_quiet;
      gap = snk_quiet ? 0 : $urandom_range(0, 12);
      if (taken == 400) gap = 300;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_transfer(m_axis_tdata);
      taken++;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_i2c_master_bit_engine_unit: errors");
    $finish;
  end

  initial begin
    logic [15:0] settings[4];
    settings      = '{16'd1, 16'd3, 16'd0, 16'd2};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(SdaRand);
    send(ReqCmd, CmdUnused6, 8'h00, 1'b0, 1'b0);
    send(ReqCmd, CmdUnused7, 8'hFF, 1'b1, 1'b1);
    send(ReqCmd, CMD_START, 8'h00, 1'b0, 1'b0);
    send(ReqCmd, CMD_WRITE, 8'hFF, 1'b1, 1'b1);
    repeat (12) send_tick(SdaRand);

    write_ticks(16'd0);
    while (sb.busy) send_tick(SdaRand);
    run_cmd(CMD_WRITE, 8'h00, 1'b0, SdaRand);
    run_cmd(CMD_WRITE, 8'hFF, 1'b1, SdaRand);
    run_cmd(CMD_READ, 8'h00, 1'b0, SdaHigh);
    run_cmd(CMD_READ, 8'hFF, 1'b1, SdaLow);
    run_cmd(CMD_SEND_ACK, 8'h00, 1'b0, SdaRand);
    run_cmd(CMD_SEND_ACK, 8'h00, 1'b1, SdaRand);
    run_cmd(CMD_GET_ACK, 8'h00, 1'b0, SdaLow);
    run_cmd(CMD_GET_ACK, 8'h00, 1'b0, SdaHigh);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SdaRand);

    // drop to a small period mid-phase so the phase ends on the next tick
    write_ticks(16'hFFFF);
    send(ReqCmd, CMD_START, 8'h00, 1'b0, 1'b1);
    repeat (6) send_tick(SdaRand);
    write_ticks(16'd2);
    while (sb.busy) send_tick(SdaRand);

    foreach (settings[k]) begin
      write_ticks(settings[k]);
      random_items(250);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_i2c_master_bit_engine_unit: clean");
    end else begin
      $display("tb_i2c_master_bit_engine_unit: errors");
    end
    $finish;
  end

endmodule
